// ===== rtl/aimd_pkg.sv =====
// shared constants, codes and types for the aimd congestion window block
// no dependencies; imported by every module of the block
`default_nettype none

package aimd_pkg;

  // fixed point format of window and threshold
  localparam int FRAC_BITS = 8;
  localparam int SEG_BITS  = 32;

  localparam int VAL_W       = 24;
  localparam int STEP_W      = 16;
  localparam int FACT_W      = 9;
  localparam int MODE_W      = 4;
  localparam int SEG_FIELD_W = 32;
  localparam int WHOLE_OUT_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 2 * VAL_W + WHOLE_OUT_W;

  // integer part of the window, used as divisor in avoidance
  localparam int WHOLE_W = VAL_W - FRAC_BITS;
  // decrease factor has 256 standing for 1.0
  localparam int DEC_SHIFT = 8;
  localparam int PROD_W    = VAL_W + FACT_W;

  localparam int DIV_CNT_W = $clog2(STEP_W);
  localparam int MUL_CNT_W = $clog2(FACT_W);

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // bit positions in mode_bits
  localparam int MODE_CONST   = 0;
  localparam int MODE_NO_CWA  = 1;
  localparam int MODE_TO_INIT = 2;
  localparam int MODE_NO_MARK = 3;

  typedef enum logic [1:0] {
    CMD_INTEREST = 2'd0,
    CMD_DATA     = 2'd1,
    CMD_LOSS     = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_WINDOW    = 3'd0,
    CFG_INIT_THRESHOLD = 3'd1,
    CFG_INCREASE_STEP  = 3'd2,
    CFG_DECREASE_FACT  = 3'd3,
    CFG_THRESH_FLOOR   = 3'd4,
    CFG_MODE_BITS      = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/aimd_div.sv =====
// bit-serial restoring divider: increase step over the integer part of the window
// one quotient bit per cycle; uses aimd_pkg
`default_nettype none

module aimd_div import aimd_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  [STEP_W-1:0]  dividend,
  input  wire  [WHOLE_W-1:0] divisor,
  output logic               done,
  output logic [STEP_W-1:0]  quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [STEP_W-1:0]    quot_r, quot_nxt;
  logic [WHOLE_W-1:0]   rem_r, rem_nxt;
  logic [WHOLE_W-1:0]   divisor_r;
  logic [WHOLE_W:0]     trial;
  logic                 fits;

  // dividend bits leave at the top of quot_r while quotient bits enter at the bottom
  always_comb begin
    trial    = {rem_r, quot_r[STEP_W-1]};
    fits     = trial >= {1'b0, divisor_r};
    rem_nxt  = fits ? WHOLE_W'(trial - {1'b0, divisor_r}) : trial[WHOLE_W-1:0];
    quot_nxt = {quot_r[STEP_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(STEP_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r    <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

// ===== rtl/aimd_mul.sv =====
// bit-serial shift-add multiplier: window times decrease factor
// one factor bit per cycle, msb first; uses aimd_pkg
`default_nettype none

module aimd_mul import aimd_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  [VAL_W-1:0]   mcand,
  input  wire  [FACT_W-1:0]  factor,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0]     mcand_r;
  logic [FACT_W-1:0]    fac_r;
  logic [PROD_W-1:0]    acc_r, acc_nxt;

  always_comb begin
    acc_nxt = {acc_r[PROD_W-2:0], 1'b0}
            + (fac_r[FACT_W-1] ? PROD_W'(mcand_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(FACT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      fac_r   <= factor;
      acc_r   <= '0;
    end else if (busy_r) begin
      fac_r <= {fac_r[FACT_W-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// ===== rtl/aimd_congestion_window_top.sv =====
// aimd congestion window controller: slow start, avoidance and recovery-gated decrease
// depends on aimd_pkg, aimd_mul and aimd_div
//
//  channel | dir    | handshake                | payload
//  in_     | slave  | in_tvalid / in_tready    | tdata seg_num, tuser cmd, is_retx, cong_mark
//  out_    | master | out_tvalid / out_tready  | tdata window, threshold, window_whole; tuser decreased
//  cfg_    | slave  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// an event passes from transfer through evaluation to the output register; a decrease adds a 9-bit serial multiply,
// a growth step in avoidance a 16-bit serial divide; one event is in work at a time
// the result sits in an output register, so the next event is taken while it waits
// rst_n (synchronous) loads the reset register values and the initial window and threshold
// cfg_ready is always high; writes are expected only while no event is in work
`default_nettype none

module aimd_congestion_window_top import aimd_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [SEG_FIELD_W-1:0]  in_tdata,   // seg_num[31:0]
  input  wire  [IN_USER_W-1:0]    in_tuser,   // cmd[1:0], is_retx[2], cong_mark[3]
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,  // window[23:0], threshold[47:24], window_whole[63:48]
  output logic [0:0]              out_tuser,  // decreased[0]
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [CFG_IDX_W-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [VAL_W-1:0]  init_window_r, floor_r;
  logic [STEP_W-1:0] step_r;
  logic [FACT_W-1:0] factor_r;
  logic [MODE_W-1:0] mode_r;

  // controller state
  logic [VAL_W-1:0]    window_r, threshold_r;
  logic [SEG_BITS-1:0] hi_int_r, hi_data_r, rec_pt_r;
  logic                got_data_r;

  // latched event
  logic [1:0]          cmd_r;
  logic [SEG_BITS-1:0] seg_r;
  logic                retx_r, mark_r;
  logic                dec_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_dec_r;

  logic in_fire, cfg_fire, out_load;
  logic is_data, marked, want_shrink, want_grow, gate_ok, shrink_ok, slow;
  logic mul_start, div_start, mul_done, div_done;
  logic [PROD_W-1:0]  product;
  logic [STEP_W-1:0]  quotient;
  logic [WHOLE_W-1:0] whole, divisor;
  logic [VAL_W-1:0]   dec_val, dec_thr;
  logic [VAL_W:0]     sum_step, sum_quot;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // event decisions taken in the evaluate cycle, and the decrease and growth values used when a serial unit is done
  always_comb begin
    is_data     = (cmd_r == CMD_DATA);
    marked      = mark_r && !mode_r[MODE_NO_MARK];
    want_shrink = (is_data && marked) || ((cmd_r == CMD_LOSS) && got_data_r);
    want_grow   = is_data && !marked && !mode_r[MODE_CONST];
    // max(hi_data, seg) > rec_pt splits into two parallel compares
    gate_ok     = mode_r[MODE_NO_CWA] || (hi_data_r > rec_pt_r)
                || (is_data && (seg_r > rec_pt_r));
    shrink_ok   = want_shrink && gate_ok;
    slow        = window_r < threshold_r;
    mul_start   = (state_r == ST_EVAL) && shrink_ok && !mode_r[MODE_CONST];
    div_start   = (state_r == ST_EVAL) && want_grow && !slow;
    whole       = window_r[VAL_W-1:FRAC_BITS];
    divisor     = (whole == '0) ? WHOLE_W'(1) : whole;
    sum_step    = {1'b0, window_r} + (VAL_W+1)'(step_r);
    sum_quot    = {1'b0, window_r} + (VAL_W+1)'(quotient);
    dec_val     = (|product[PROD_W-1:VAL_W+DEC_SHIFT]) ? VAL_MAX
                : product[VAL_W+DEC_SHIFT-1:DEC_SHIFT];
    dec_thr     = (dec_val < floor_r) ? floor_r : dec_val;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL: begin
        priority if (mul_start) state_nxt = ST_MUL;
        else if (div_start)     state_nxt = ST_DIV;
        else                    state_nxt = ST_OUT;
      end
      ST_MUL:  if (mul_done) state_nxt = ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  aimd_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (window_r),
    .factor  (factor_r),
    .done    (mul_done),
    .product (product)
  );

  aimd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (step_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // event latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_tuser[1:0];
      seg_r  <= SEG_BITS'(in_tdata);
      retx_r <= in_tuser[2];
      mark_r <= in_tuser[3];
    end
  end

  // controller state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_window_r    <= VAL_W'(256);
      step_r           <= STEP_W'(256);
      factor_r         <= FACT_W'(128);
      floor_r          <= VAL_W'(512);
      mode_r           <= '0;
      window_r         <= VAL_W'(256);
      threshold_r      <= VAL_MAX;
      hi_int_r         <= '0;
      hi_data_r        <= '0;
      rec_pt_r         <= '0;
      got_data_r       <= 1'b0;
      dec_r            <= 1'b0;
    end else begin
      if (state_r == ST_EVAL) begin
        dec_r <= 1'b0;
        if ((cmd_r == CMD_INTEREST) && !retx_r) hi_int_r <= seg_r;
        if (is_data) begin
          got_data_r <= 1'b1;
          if (seg_r > hi_data_r) hi_data_r <= seg_r;
        end
        if (shrink_ok) rec_pt_r <= hi_int_r;
        if (want_grow && slow) window_r <= sum_step[VAL_W] ? VAL_MAX : sum_step[VAL_W-1:0];
      end
      if (mul_done) begin
        threshold_r <= dec_thr;
        window_r    <= mode_r[MODE_TO_INIT] ? init_window_r : dec_thr;
        dec_r       <= 1'b1;
      end
      if (div_done) window_r <= sum_quot[VAL_W] ? VAL_MAX : sum_quot[VAL_W-1:0];
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_INIT_WINDOW: begin
            init_window_r <= cfg_data[VAL_W-1:0];
            window_r      <= cfg_data[VAL_W-1:0];
          end
          // the initial threshold only matters as the value loaded here
          CFG_INIT_THRESHOLD: threshold_r <= cfg_data[VAL_W-1:0];
          CFG_INCREASE_STEP:  step_r      <= cfg_data[STEP_W-1:0];
          CFG_DECREASE_FACT:  factor_r    <= cfg_data[FACT_W-1:0];
          CFG_THRESH_FLOOR:   floor_r     <= cfg_data[VAL_W-1:0];
          CFG_MODE_BITS:      mode_r      <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {WHOLE_OUT_W'(window_r >> FRAC_BITS), threshold_r, window_r};
      out_dec_r  <= dec_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dec_r;

  // a result only appears after the controller reached its output state
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result presented without a finished event");

  // serial units finish only in the state that waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside its wait state");

  // a decrease never leaves the threshold under the floor
  a_floor_kept: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done && !cfg_fire |=> threshold_r >= floor_r)
    else $error("threshold below floor after decrease");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for aimd_congestion_window_top: directed and random fetch traffic under several
// register settings, a bursty sender and a stalling receiver, checked against a window model
// depends on aimd_pkg and the rtl of the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aimd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 40;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 115;

  localparam logic [1:0]           CMD_UNKNOWN    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 3'd7;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_LONG   = 3;

  typedef struct {
    logic [1:0]             cmd;
    logic [SEG_FIELD_W-1:0] seg;
    logic                   retx;
    logic                   mark;
    bit                     drain;
  } fetch_event_t;

  typedef struct {
    logic [VAL_W-1:0]       window;
    logic [VAL_W-1:0]       threshold;
    logic [WHOLE_OUT_W-1:0] whole;
    logic                   decreased;
  } window_state_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [SEG_FIELD_W-1:0] in_tdata   = '0;
  logic [IN_USER_W-1:0]   in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  aimd_congestion_window_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // window model: registers and state
  logic [VAL_W-1:0]    cw_init_win, cw_init_thr, cw_floor, cw_win, cw_thr;
  logic [STEP_W-1:0]   cw_step;
  logic [FACT_W-1:0]   cw_fact;
  logic [MODE_W-1:0]   cw_mode;
  logic [SEG_BITS-1:0] cw_hi_int, cw_hi_data, cw_recover;
  logic                cw_got_data;

  fetch_event_t  event_q[$];
  window_state_t window_q[$];
  int            fail_cnt  = 0;
  int            cycle_cnt = 0;
  bit            in_fire   = 1'b0;
  logic [SEG_BITS-1:0] seq_sent = '0;
  logic [SEG_BITS-1:0] seq_rcvd = '0;

  function automatic void reset_window_model();
    cw_init_win = 24'd256;
    cw_init_thr = VAL_MAX;
    cw_step     = 16'd256;
    cw_fact     = 9'd128;
    cw_floor    = 24'd512;
    cw_mode     = '0;
    cw_win      = cw_init_win;
    cw_thr      = cw_init_thr;
    cw_hi_int   = '0;
    cw_hi_data  = '0;
    cw_recover  = '0;
    cw_got_data = 1'b0;
  endfunction

  function automatic void write_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_INIT_WINDOW: begin
        cw_init_win = val[VAL_W-1:0];
        cw_win      = cw_init_win;
      end
      CFG_INIT_THRESHOLD: begin
        cw_init_thr = val[VAL_W-1:0];
        cw_thr      = cw_init_thr;
      end
      CFG_INCREASE_STEP: cw_step  = val[STEP_W-1:0];
      CFG_DECREASE_FACT: cw_fact  = val[FACT_W-1:0];
      CFG_THRESH_FLOOR:  cw_floor = val[VAL_W-1:0];
      CFG_MODE_BITS:     cw_mode  = val[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] clamp_val(input logic [47:0] v);
    return (v > 48'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

  function automatic void grow_window();
    logic [47:0]        sum;
    logic [WHOLE_W-1:0] whole;
    if (cw_mode[MODE_CONST])
      return;
    if (cw_win < cw_thr) begin
      sum = 48'(cw_win) + 48'(cw_step);
    end else begin
      // avoidance: step over the integer part, a zero integer part counts as one
      whole = WHOLE_W'(cw_win >> FRAC_BITS);
      if (whole == '0)
        whole = WHOLE_W'(1);
      sum = 48'(cw_win) + 48'(cw_step / whole);
    end
    cw_win = clamp_val(sum);
  endfunction

  function automatic logic shrink_window();
    logic [47:0]      prod;
    logic [VAL_W-1:0] t;
    if (!(cw_mode[MODE_NO_CWA] || cw_hi_data > cw_recover))
      return 1'b0;
    cw_recover = cw_hi_int;
    // constant window still moves the recovery point
    if (cw_mode[MODE_CONST])
      return 1'b0;
    prod = (48'(cw_win) * 48'(cw_fact)) >> DEC_SHIFT;
    t = clamp_val(prod);
    if (t < cw_floor)
      t = cw_floor;
    cw_thr = t;
    cw_win = cw_mode[MODE_TO_INIT] ? cw_init_win : cw_thr;
    return 1'b1;
  endfunction

  function automatic window_state_t predict_window(input fetch_event_t ev);
    window_state_t r;
    logic          dec;
    dec = 1'b0;
    case (ev.cmd)
      CMD_INTEREST: begin
        if (!ev.retx)
          cw_hi_int = ev.seg;
      end
      CMD_DATA: begin
        cw_got_data = 1'b1;
        if (cw_hi_data < ev.seg)
          cw_hi_data = ev.seg;
        if (ev.mark && !cw_mode[MODE_NO_MARK])
          dec = shrink_window();
        else
          grow_window();
      end
      CMD_LOSS: begin
        // a loss before any data is ignored
        if (cw_got_data)
          dec = shrink_window();
      end
      default: ;
    endcase
    r.window    = cw_win;
    r.threshold = cw_thr;
    r.whole     = WHOLE_OUT_W'(cw_win >> FRAC_BITS);
    r.decreased = dec;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (fail_cnt < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // monitor: follows register writes, predicts on input transfers, checks result transfers
  always @(posedge clk) begin
    window_state_t got, want;
    fetch_event_t  ev;
    if (!rst_n) begin
      reset_window_model();
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready)
        write_window_reg(cfg_index, cfg_data);
      if (out_tvalid && out_tready) begin
        got.window    = out_tdata[0 +: VAL_W];
        got.threshold = out_tdata[VAL_W +: VAL_W];
        got.whole     = out_tdata[2*VAL_W +: WHOLE_OUT_W];
        got.decreased = out_tuser[0];
        if (window_q.size() == 0) begin
          $display("%0t ns: result with none expected, expected nothing actual %0h/%0h",
                   $time, out_tdata, out_tuser);
          fail_cnt++;
        end else begin
          want = window_q.pop_front();
          check_field("window", 32'(want.window), 32'(got.window));
          check_field("threshold", 32'(want.threshold), 32'(got.threshold));
          check_field("window_whole", 32'(want.whole), 32'(got.whole));
          check_field("decreased", 32'(want.decreased), 32'(got.decreased));
        end
      end
      if (in_tvalid && in_tready) begin
        ev.cmd   = in_tuser[1:0];
        ev.retx  = in_tuser[2];
        ev.mark  = in_tuser[3];
        ev.seg   = in_tdata;
        ev.drain = 1'b0;
        window_q.push_back(predict_window(ev));
      end
    end
  end

  // sender: bursts and gaps, holds an item until its transfer
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    fetch_event_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // still waiting for the transfer
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (event_q.size() == 0 || (event_q[0].drain && window_q.size() != 0)) begin
      in_tvalid <= 1'b0;
    end else begin
      ev = event_q.pop_front();
      in_tdata  <= ev.seg;
      in_tuser  <= {ev.mark, ev.retx, ev.cmd};
      in_tvalid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // receiver: stall pattern is drawn anew at random, paced by cycle_cnt
  int rx_mode = RX_OPEN;
  int rx_hold = 0;

  always @(negedge clk) begin
    if (cycle_cnt % 150 == 0)
      rx_mode = $urandom_range(RX_OPEN, RX_LONG);
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) != 0);
        default: begin
          if ($urandom_range(0, 11) == 0) begin
            rx_hold = $urandom_range(3, 15);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits beyond the register width carry junk in the mode, step and factor writes
  task automatic program_cfg(input logic [VAL_W-1:0] win0, input logic [VAL_W-1:0] thr0,
                             input logic [STEP_W-1:0] step, input logic [FACT_W-1:0] fact,
                             input logic [VAL_W-1:0] floor_v, input logic [MODE_W-1:0] mode);
    write_reg(CFG_MODE_BITS, {20'($urandom), mode});
    write_reg(CFG_INCREASE_STEP, {8'($urandom), step});
    write_reg(CFG_DECREASE_FACT, {15'($urandom), fact});
    write_reg(CFG_THRESH_FLOOR, floor_v);
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_IDX : CFG_UNUSED_TOP, 24'($urandom));
    write_reg(CFG_INIT_THRESHOLD, thr0);
    write_reg(CFG_INIT_WINDOW, win0);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int spins;
    spins = 0;
    while (event_q.size() != 0 || in_tvalid)
      @(posedge clk);
    while (window_q.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (window_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected %0h actual none",
               $time, window_q.size(), window_q[0].window);
      fail_cnt++;
      window_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_event(input logic [1:0] cmd, input logic [SEG_FIELD_W-1:0] seg,
                            input logic retx, input logic mark);
    fetch_event_t ev;
    ev.cmd   = cmd;
    ev.seg   = seg;
    ev.retx  = retx;
    ev.mark  = mark;
    ev.drain = 1'b0;
    event_q.push_back(ev);
  endtask

  // mostly an orderly fetch: interests ahead, data behind, some marks, losses and noise
  task automatic queue_fetch(input int n, input int mark_pct);
    int           pick;
    fetch_event_t ev;
    for (int i = 0; i < n; i++) begin
      pick     = $urandom_range(0, 99);
      ev.drain = ($urandom_range(0, 59) == 0);
      ev.retx  = 1'b0;
      ev.mark  = 1'b0;
      if (pick < 38 || (pick < 72 && seq_rcvd == seq_sent)) begin
        ev.cmd = CMD_INTEREST;
        ev.seg = seq_sent;
        seq_sent++;
      end else if (pick < 72) begin
        ev.cmd  = CMD_DATA;
        ev.seg  = seq_rcvd;
        ev.mark = ($urandom_range(0, 99) < mark_pct);
        seq_rcvd++;
      end else if (pick < 78) begin
        // late data below the highest seen
        ev.cmd  = CMD_DATA;
        ev.seg  = (seq_rcvd > 8) ? seq_rcvd - $urandom_range(1, 8) : '0;
        ev.mark = 1'($urandom_range(0, 1));
      end else if (pick < 86) begin
        ev.cmd = CMD_LOSS;
        ev.seg = seq_rcvd;
      end else if (pick < 91) begin
        ev.cmd  = CMD_INTEREST;
        ev.retx = 1'b1;
        ev.seg  = $urandom;
      end else begin
        ev.cmd  = (pick < 94) ? CMD_UNKNOWN : CMD_LOSS;
        ev.seg  = $urandom;
        ev.retx = 1'($urandom_range(0, 1));
        ev.mark = 1'($urandom_range(0, 1));
      end
      event_q.push_back(ev);
    end
  endtask

  initial begin
    logic [VAL_W-1:0]  win0, thr0, floor_v;
    logic [STEP_W-1:0] step;
    logic [FACT_W-1:0] fact;
    logic [MODE_W-1:0] mode;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: loss before data, recovery gate, retransmitted interest, bad command
    push_event(CMD_LOSS, 32'd7, 1'b0, 1'b1);
    push_event(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_event(CMD_INTEREST, 32'd10, 1'b0, 1'b0);
    push_event(CMD_INTEREST, 32'd99, 1'b1, 1'b0);
    push_event(CMD_DATA, 32'd0, 1'b0, 1'b0);
    push_event(CMD_DATA, 32'd3, 1'b0, 1'b1);
    push_event(CMD_DATA, 32'd4, 1'b0, 1'b1);
    push_event(CMD_LOSS, 32'd4, 1'b0, 1'b0);
    push_event(CMD_DATA, 32'd11, 1'b1, 1'b0);
    push_event(CMD_LOSS, 32'd12, 1'b0, 1'b0);
    push_event(CMD_INTEREST, 32'd14, 1'b0, 1'b0);
    push_event(CMD_DATA, 32'd13, 1'b0, 1'b0);
    push_event(CMD_UNKNOWN, 32'd0, 1'b0, 1'b0);
    seq_sent = 32'd16;
    seq_rcvd = 32'd16;
    wait_idle();

    // saturation at the top of the range
    program_cfg(24'hFFFF00, VAL_MAX, 16'hFFFF, 9'd256, VAL_MAX, 4'd0);
    @(posedge clk);
    queue_fetch(20, 25);
    wait_idle();

    // everything collapses to zero, divisor falls back to one
    program_cfg(24'd256, 24'd0, 16'd300, 9'd0, 24'd0, 4'b0010);
    @(posedge clk);
    queue_fetch(20, 25);
    wait_idle();

    // constant window with marks ignored, factor above one
    program_cfg(24'd1000, 24'd2000, 16'd0, 9'd511, 24'd0, 4'b1001);
    @(posedge clk);
    queue_fetch(20, 25);
    wait_idle();

    // back to the initial window on each decrease
    program_cfg(VAL_MAX, 24'h800, 16'd1, 9'd511, 24'd100, 4'b0110);
    @(posedge clk);
    queue_fetch(20, 25);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      win0 = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(256, VAL_MAX))
                                         : 24'($urandom_range(256, 4096));
      case ($urandom_range(0, 3))
        0:       thr0 = '0;
        1:       thr0 = VAL_MAX;
        default: thr0 = 24'($urandom_range(256, 16384));
      endcase
      step    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      fact    = FACT_W'($urandom_range(0, 511));
      floor_v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2048));
      mode    = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
      program_cfg(win0, thr0, step, fact, floor_v, mode);
      @(posedge clk);
      queue_fetch(PHASE_ITEMS, $urandom_range(5, 20));
      wait_idle();
    end

    // top of the segment range, kept for last since the highest data never falls
    program_cfg(24'd256, VAL_MAX, 16'd256, 9'd128, 24'd512, 4'd0);
    @(posedge clk);
    push_event(CMD_INTEREST, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_event(CMD_DATA, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_event(CMD_DATA, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_event(CMD_LOSS, 32'd0, 1'b0, 1'b0);
    push_event(CMD_DATA, 32'hFFFF_FFFE, 1'b0, 1'b0);
    push_event(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    wait_idle();

    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aimd_pkg.sv
rtl/aimd_div.sv
rtl/aimd_mul.sv
rtl/aimd_congestion_window_top.sv
dv/tb.sv
